// ----- sv/uqd_pkg.sv -----
// shared types and constants for the urlencoded query decoder
// no dependencies; used by every module of the block
`default_nettype none

package uqd_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_NAME_END  = 3'd1,
    KIND_VALUE_END = 3'd2,
    KIND_BARE_END  = 3'd3,
    KIND_QUERY_END = 3'd4
  } kind_t;

  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQ      = 8'h3d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CASE_MASK  = 8'hdf;

  typedef struct packed {
    logic       last;
    logic       done;
    logic       bad;
    logic [7:0] ch;
    kind_t      kind;
  } result_t;

  // one queue entry carries all results of one input byte
  typedef struct packed {
    logic    two;
    result_t r1;
    result_t r0;
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/urlencoded_query_decoder_top.sv -----
// urlencoded query string decoder: one raw byte in, decoded bytes and markers out
// an accepted byte's results are written into the queue, then popped into the output register
// throughput: one byte per cycle while the queue is not full; a byte giving two results shows them in turn
// the output stage sets the sustained rate; the queue absorbs short bursts of two results
// reset: synchronous active-low rst_n returns to no token open and empties the queue
// depends on uqd_pkg, uqd_front, uqd_fifo, uqd_back
`default_nettype none

module urlencoded_query_decoder_top #(
  parameter int QUEUE_DEPTH = uqd_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // char_in[7:0]
  input  wire logic       in_tlast,   // final_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // char_out[7:0]
  output logic [4:0]      out_tuser,  // kind[2:0], bad_escape[3], query_done[4]
  output logic            out_tlast   // run_last
);

  logic             in_fire, push, full, empty, pop;
  uqd_pkg::entry_t  push_data, rd_data;
  uqd_pkg::result_t res;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  uqd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .char_in    (in_tdata),
    .final_byte (in_tlast),
    .push       (push),
    .push_data  (push_data)
  );

  uqd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .full    (full),
    .pop     (pop),
    .rd_data (rd_data),
    .empty   (empty)
  );

  uqd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (empty),
    .q_data  (rd_data),
    .q_pop   (pop),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (res)
  );

  assign out_tdata = res.ch;
  assign out_tuser = {res.done, res.bad, res.kind};
  assign out_tlast = res.last;

endmodule

`default_nettype wire

// ----- sv/uqd_front.sv -----
// front end: accepts query bytes, tracks token and escape state, forms results
// depends on uqd_pkg
`default_nettype none

module uqd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic [7:0]      char_in,
  input  wire logic            final_byte,
  output logic                 push,
  output uqd_pkg::entry_t      push_data
);

  logic       in_value_r, in_value_nxt;
  logic       token_open_r, token_open_nxt;
  logic [1:0] escape_stage_r, escape_stage_nxt;
  logic [7:0] escape_accum_r, escape_accum_nxt;
  logic       escape_dropped_r, escape_dropped_nxt;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] cc;
    begin
      cc = (c == uqd_pkg::CH_PLUS) ? uqd_pkg::CH_SPACE : c;
      if (cc >= uqd_pkg::CH_UPPER_A)
        digit_of = (cc & uqd_pkg::CASE_MASK) - uqd_pkg::CH_UPPER_A + 8'd10;
      else
        digit_of = cc - uqd_pkg::CH_ZERO;
    end
  endfunction

  function automatic uqd_pkg::result_t mk_res(input uqd_pkg::kind_t k, input logic [7:0] ch,
                                              input logic bad, input logic done);
    uqd_pkg::result_t r;
    begin
      r.kind = k;
      r.ch   = ch;
      r.bad  = bad;
      r.done = done;
      r.last = 1'b0;
      mk_res = r;
    end
  endfunction

  uqd_pkg::result_t em0, em1, em;
  logic [1:0]       cnt;
  logic             is_amp, is_eq, emit_en;
  logic [7:0]       dig;

  always_comb begin
    is_amp = (char_in == uqd_pkg::CH_AMP);
    is_eq  = (char_in == uqd_pkg::CH_EQ);
    dig    = digit_of(char_in);

    in_value_nxt       = in_value_r;
    token_open_nxt     = token_open_r;
    escape_stage_nxt   = escape_stage_r;
    escape_accum_nxt   = escape_accum_r;
    escape_dropped_nxt = escape_dropped_r;

    em0     = mk_res(uqd_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0);
    em1     = em0;
    em      = em0;
    emit_en = 1'b0;
    cnt     = 2'd0;

    // separators cut a pending escape short
    if ((is_amp || is_eq) && escape_stage_nxt != 2'd0) begin
      escape_dropped_nxt = 1'b1;
      escape_stage_nxt   = 2'd0;
      escape_accum_nxt   = 8'h00;
    end

    if (is_amp) begin
      if (token_open_nxt) begin
        em = mk_res(in_value_nxt ? uqd_pkg::KIND_VALUE_END : uqd_pkg::KIND_BARE_END,
                    8'h00, escape_dropped_nxt, 1'b0);
        emit_en = 1'b1;
      end
      in_value_nxt       = 1'b0;
      token_open_nxt     = 1'b0;
      escape_stage_nxt   = 2'd0;
      escape_accum_nxt   = 8'h00;
      escape_dropped_nxt = 1'b0;
    end else if (is_eq && !in_value_nxt) begin
      em = mk_res(uqd_pkg::KIND_NAME_END, 8'h00, escape_dropped_nxt, 1'b0);
      emit_en            = 1'b1;
      escape_dropped_nxt = 1'b0;
      in_value_nxt       = 1'b1;
      token_open_nxt     = 1'b1;
    end else begin
      token_open_nxt = 1'b1;
      if (escape_stage_nxt == 2'd1) begin
        escape_accum_nxt = dig;
        escape_stage_nxt = 2'd2;
      end else if (escape_stage_nxt >= 2'd2) begin
        em = mk_res(uqd_pkg::KIND_DATA, {escape_accum_nxt[3:0], 4'h0} + dig, 1'b0, 1'b0);
        emit_en          = 1'b1;
        escape_stage_nxt = 2'd0;
        escape_accum_nxt = 8'h00;
      end else if (char_in == uqd_pkg::CH_PCT) begin
        escape_stage_nxt = 2'd1;
        escape_accum_nxt = 8'h00;
      end else if (char_in == uqd_pkg::CH_PLUS) begin
        em = mk_res(uqd_pkg::KIND_DATA, uqd_pkg::CH_SPACE, 1'b0, 1'b0);
        emit_en = 1'b1;
      end else begin
        em = mk_res(uqd_pkg::KIND_DATA, char_in, 1'b0, 1'b0);
        emit_en = 1'b1;
      end
    end

    if (emit_en) begin
      em0 = em;
      cnt = 2'd1;
    end

    if (final_byte) begin
      if (token_open_nxt)
        em = mk_res(in_value_nxt ? uqd_pkg::KIND_VALUE_END : uqd_pkg::KIND_BARE_END, 8'h00,
                    escape_dropped_nxt | (escape_stage_nxt != 2'd0), 1'b1);
      else
        em = mk_res(uqd_pkg::KIND_QUERY_END, 8'h00, 1'b0, 1'b1);
      if (cnt == 2'd0)
        em0 = em;
      else
        em1 = em;
      cnt = cnt + 2'd1;
      in_value_nxt       = 1'b0;
      token_open_nxt     = 1'b0;
      escape_stage_nxt   = 2'd0;
      escape_accum_nxt   = 8'h00;
      escape_dropped_nxt = 1'b0;
    end

    if (cnt == 2'd2)
      em1.last = 1'b1;
    else
      em0.last = 1'b1;

    push_data.two = (cnt == 2'd2);
    push_data.r0  = em0;
    push_data.r1  = em1;
    push          = in_fire && (cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r       <= 1'b0;
      token_open_r     <= 1'b0;
      escape_stage_r   <= 2'd0;
      escape_accum_r   <= 8'h00;
      escape_dropped_r <= 1'b0;
    end else if (in_fire) begin
      in_value_r       <= in_value_nxt;
      token_open_r     <= token_open_nxt;
      escape_stage_r   <= escape_stage_nxt;
      escape_accum_r   <= escape_accum_nxt;
      escape_dropped_r <= escape_dropped_nxt;
    end
  end

  // a closed token leaves no escape or value state behind
  a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !token_open_r |-> (escape_stage_r == 2'd0 && !in_value_r && !escape_dropped_r))
    else $error("state left over with no token open");

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    escape_stage_r != 2'd3)
    else $error("escape stage out of range");

endmodule

`default_nettype wire

// ----- sv/uqd_fifo.sv -----
// short result queue between front end and output stage
// depends on uqd_pkg for the entry type
`default_nettype none

module uqd_fifo #(
  parameter int DEPTH = uqd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire uqd_pkg::entry_t wr_data,
  output logic                 full,
  input  wire logic            pop,
  output uqd_pkg::entry_t      rd_data,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  uqd_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)
        count_r <= count_r + 1'b1;
      else if (pop && !push)
        count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- sv/uqd_back.sv -----
// output stage: pops queue entries and sends their results one per cycle while out_rdy takes them
// depends on uqd_pkg
`default_nettype none

module uqd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire uqd_pkg::entry_t q_data,
  output logic                 q_pop,
  output logic                 out_vld,
  input  wire logic            out_rdy,
  output uqd_pkg::result_t     out_res
);

  logic             out_vld_r, out_vld_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  uqd_pkg::result_t out_res_r, out_res_nxt;
  uqd_pkg::result_t pend_res_r, pend_res_nxt;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    pend_vld_nxt = pend_vld_r;
    out_res_nxt  = out_res_r;
    pend_res_nxt = pend_res_r;
    q_pop        = 1'b0;
    if (!out_vld_r || out_rdy) begin
      if (pend_vld_r) begin
        out_res_nxt  = pend_res_r;
        out_vld_nxt  = 1'b1;
        pend_vld_nxt = 1'b0;
      end else if (!q_empty) begin
        q_pop        = 1'b1;
        out_res_nxt  = q_data.r0;
        out_vld_nxt  = 1'b1;
        pend_res_nxt = q_data.r1;
        pend_vld_nxt = q_data.two;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_vld = out_vld_r;
  assign out_res = out_res_r;

  // a held second result always sits behind a shown first one
  a_pend_behind: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (out_vld_r && !out_res_r.last))
    else $error("second result held without its first");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// testbench for urlencoded_query_decoder_top: directed and random query strings on the
// input stream, each result checked against a built-in decoder model as it arrives
// depends on uqd_pkg and urlencoded_query_decoder_top
`timescale 1ns / 100ps

module tb;

  localparam int ITEM_TARGET = 1850;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } query_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [4:0] out_tuser;
  logic       out_tlast;

  query_byte_t      query_stream[$];
  logic [7:0]       query_bytes[$];
  uqd_pkg::result_t decoded_results[$];

  // decoder model state
  logic       in_value = 1'b0;
  logic       token_open = 1'b0;
  logic [1:0] esc_stage = 2'd0;
  logic [7:0] esc_accum = 8'h00;
  logic       esc_dropped = 1'b0;

  logic in_taken = 1'b0;
  int   bytes_sent = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   cycles = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  // both sides run without gaps through this window
  wire calm = (bytes_sent >= 800) && (bytes_sent < 1200);

  urlencoded_query_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] x;
    x = (c == uqd_pkg::CH_PLUS) ? uqd_pkg::CH_SPACE : c;
    if (x >= uqd_pkg::CH_UPPER_A)
      return (x & uqd_pkg::CASE_MASK) - uqd_pkg::CH_UPPER_A + 8'd10;
    return x - uqd_pkg::CH_ZERO;
  endfunction

  function automatic uqd_pkg::result_t make_result(input uqd_pkg::kind_t kind,
                                                   input logic [7:0] ch,
                                                   input logic bad, input logic done);
    uqd_pkg::result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.bad  = bad;
    r.done = done;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void clear_token();
    in_value    = 1'b0;
    token_open  = 1'b0;
    esc_stage   = 2'd0;
    esc_accum   = 8'h00;
    esc_dropped = 1'b0;
  endfunction

  // decode one raw byte and queue the results it gives
  function automatic void decode_byte(input logic [7:0] c, input logic fin);
    uqd_pkg::result_t res[2];
    int               n = 0;
    logic [7:0]       b;
    logic             bad;
    if ((c == uqd_pkg::CH_AMP || c == uqd_pkg::CH_EQ) && esc_stage != 2'd0) begin
      esc_dropped = 1'b1;
      esc_stage   = 2'd0;
      esc_accum   = 8'h00;
    end
    if (c == uqd_pkg::CH_AMP) begin
      if (token_open) begin
        res[n] = make_result(in_value ? uqd_pkg::KIND_VALUE_END : uqd_pkg::KIND_BARE_END,
                             8'h00, esc_dropped, 1'b0);
        n++;
      end
      clear_token();
    end else if (c == uqd_pkg::CH_EQ && !in_value) begin
      res[n] = make_result(uqd_pkg::KIND_NAME_END, 8'h00, esc_dropped, 1'b0);
      n++;
      esc_dropped = 1'b0;
      in_value    = 1'b1;
      token_open  = 1'b1;
    end else begin
      token_open = 1'b1;
      if (esc_stage == 2'd1) begin
        esc_accum = digit_value(c);
        esc_stage = 2'd2;
      end else if (esc_stage >= 2'd2) begin
        b = {esc_accum[3:0], 4'h0} + digit_value(c);
        esc_stage = 2'd0;
        esc_accum = 8'h00;
        res[n] = make_result(uqd_pkg::KIND_DATA, b, 1'b0, 1'b0);
        n++;
      end else if (c == uqd_pkg::CH_PCT) begin
        esc_stage = 2'd1;
        esc_accum = 8'h00;
      end else begin
        res[n] = make_result(uqd_pkg::KIND_DATA,
                             (c == uqd_pkg::CH_PLUS) ? uqd_pkg::CH_SPACE : c, 1'b0, 1'b0);
        n++;
      end
    end
    if (fin) begin
      if (token_open) begin
        bad = esc_dropped | (esc_stage != 2'd0);
        res[n] = make_result(in_value ? uqd_pkg::KIND_VALUE_END : uqd_pkg::KIND_BARE_END,
                             8'h00, bad, 1'b1);
      end else begin
        res[n] = make_result(uqd_pkg::KIND_QUERY_END, 8'h00, 1'b0, 1'b1);
      end
      n++;
      clear_token();
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) decoded_results.push_back(res[i]);
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("tb: mismatch %s", msg);
  endfunction

  function automatic void check_result();
    uqd_pkg::result_t want;
    logic [2:0] got_kind;
    logic got_bad;
    logic got_done;
    got_kind = out_tuser[2:0];
    got_bad  = out_tuser[3];
    got_done = out_tuser[4];
    results_seen++;
    if (decoded_results.size() == 0) begin
      note_error($sformatf({"result %0d with none expected: ",
                            "kind %0d ch %02h bad %0b done %0b last %0b"},
                           results_seen, got_kind, out_tdata, got_bad, got_done, out_tlast));
      return;
    end
    want = decoded_results.pop_front();
    if (got_kind !== want.kind || out_tdata !== want.ch || got_bad !== want.bad ||
        got_done !== want.done || out_tlast !== want.last)
      note_error($sformatf({"result %0d: expected kind %0d ch %02h bad %0b done %0b last %0b, ",
                            "got kind %0d ch %02h bad %0b done %0b last %0b"},
                           results_seen, want.kind, want.ch, want.bad, want.done, want.last,
                           got_kind, out_tdata, got_bad, got_done, out_tlast));
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return uqd_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? uqd_pkg::CH_UPPER_A : 8'h61) + 8'(v - 10);
  endfunction

  function automatic void add_text(input int len);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          case ($urandom_range(0, 2))
            0: query_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
            1: query_bytes.push_back(uqd_pkg::CH_UPPER_A + 8'($urandom_range(0, 25)));
            default: query_bytes.push_back(uqd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          endcase
        end
        11, 12: query_bytes.push_back(uqd_pkg::CH_PLUS);
        13, 14, 15: begin
          query_bytes.push_back(uqd_pkg::CH_PCT);
          query_bytes.push_back(hex_char());
          query_bytes.push_back(hex_char());
        end
        // escape with at most one hex digit, completed or cut short by whatever follows
        16: begin
          query_bytes.push_back(uqd_pkg::CH_PCT);
          if ($urandom_range(0, 1)) query_bytes.push_back(hex_char());
        end
        default: query_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // move the built query into the send queue, the final byte flagged
  function automatic void flush_query();
    for (int i = 0; i < query_bytes.size(); i++)
      query_stream.push_back(query_byte_t'{ch: query_bytes[i],
                                           fin: (i == query_bytes.size() - 1)});
    query_bytes.delete();
  endfunction

  function automatic void add_random_query();
    int tokens;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) query_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      tokens = $urandom_range(0, 4);
      for (int t = 0; t < tokens; t++) begin
        if (t != 0 || $urandom_range(0, 7) == 0) query_bytes.push_back(uqd_pkg::CH_AMP);
        if ($urandom_range(0, 7) == 0) query_bytes.push_back(uqd_pkg::CH_AMP);
        if ($urandom_range(0, 4) != 0) begin
          add_text($urandom_range(0, 4));
          query_bytes.push_back(uqd_pkg::CH_EQ);
        end
        add_text($urandom_range(0, 5));
      end
      if (query_bytes.size() == 0 || $urandom_range(0, 5) == 0)
        query_bytes.push_back(uqd_pkg::CH_AMP);
    end
    flush_query();
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the offered byte until it is taken
    end else if (query_stream.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= query_stream[0].ch;
      in_tlast  <= query_stream[0].fin;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && bytes_sent >= 300) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // monitor: model runs on each input transaction, each output transaction is checked
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      decode_byte(in_tdata, in_tlast);
      query_stream.delete(0);
      bytes_sent++;
    end
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    // lone separator: empty token, then query end with nothing open
    query_bytes = {uqd_pkg::CH_AMP};
    flush_query();
    // extreme bytes, escapes with odd digits, later '=', escapes cut by '&' and '='
    query_bytes = {8'h00, uqd_pkg::CH_EQ, uqd_pkg::CH_PCT, 8'h34, 8'h31, uqd_pkg::CH_EQ,
                   uqd_pkg::CH_PCT, uqd_pkg::CH_PLUS, uqd_pkg::CH_PCT, 8'hff,
                   uqd_pkg::CH_PCT, uqd_pkg::CH_AMP, uqd_pkg::CH_AMP, uqd_pkg::CH_PCT, 8'h33,
                   uqd_pkg::CH_EQ, 8'h7a};
    flush_query();
    // escape cut by end of input
    query_bytes = {8'h6b, uqd_pkg::CH_PCT, 8'h37};
    flush_query();
    // bare value ended by '&', then a lone '%' at the end
    query_bytes = {8'h62, uqd_pkg::CH_AMP, uqd_pkg::CH_PCT};
    flush_query();
    while (query_stream.size() < ITEM_TARGET) add_random_query();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (query_stream.size() != 0 || decoded_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && decoded_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
